// ===== rtl/blp_pkg.sv =====
package blp_pkg;

  localparam int FULL_CURRENT = 1000;
  localparam int DUTY_HIGH    = 255;
  localparam int DUTY_MID     = 128;
  localparam int DUTY_LOW     = 0;
  localparam bit INVERT_DUTY  = 1'b0;

  // Fixed arithmetic of the check path.
  localparam logic [10:0] VOLT_SCALE  = 11'd1086;
  localparam logic [13:0] WATT_SCALE  = 14'd10000;
  localparam int          DIV_W       = 30;
  localparam logic [4:0]  DIV_STEPS   = 5'd30;
  localparam logic [7:0]  DUTY_MAX    = 8'd255;

  // Division by 100 as a multiplication by ceil(2^30 / 100) and a shift by 30.
  // It is exact for every product of a 16-bit limit and a 7-bit brightness.
  localparam logic [23:0] PCT_RECIP   = 24'd10737419;
  localparam int          PCT_SHIFT   = 30;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_VTH0 = 3'd0;
  localparam logic [2:0] REG_VTH1 = 3'd1;
  localparam logic [2:0] REG_VTH2 = 3'd2;
  localparam logic [2:0] REG_VTH3 = 3'd3;
  localparam logic [2:0] REG_WB0  = 3'd4;
  localparam logic [2:0] REG_WB1  = 3'd5;
  localparam logic [2:0] REG_WB2  = 3'd6;
  localparam logic [2:0] REG_WB3  = 3'd7;

  localparam logic       KIND_INIT  = 1'b0;
  localparam logic       KIND_CHECK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCALE,
    ST_BUDGET,
    ST_CAP_LOAD,
    ST_CAP_RUN,
    ST_LOWER,
    ST_TGT_LOAD,
    ST_TGT_RUN,
    ST_SEARCH_INIT,
    ST_SEARCH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic do_init;
    logic do_scale;
    logic do_budget;
    logic div_load;
    logic do_lower;
    logic tgt_mul;
    logic tgt_scale;
    logic search_init;
    logic search_step;
    logic out_load;
  } blp_cmd_t;

  typedef struct packed {
    logic kind;
    logic volt_zero;
    logic div_busy;
    logic lower;
    logic found;
    logic out_free;
  } blp_status_t;

  localparam logic [9:0] CURVE_MILLI [256] = '{
    0,5,8,13,15,20,25,28,30,35,38,43,45,51,56,58,
    63,66,71,73,76,81,83,88,91,96,98,104,106,111,116,119,
    124,126,131,134,139,141,146,149,154,159,162,167,169,174,177,182,
    184,189,194,197,202,205,210,212,217,222,225,230,232,237,240,245,
    250,253,258,260,265,268,273,275,280,283,288,290,295,301,303,308,
    311,316,321,323,328,333,336,341,343,348,351,356,361,364,369,374,
    376,381,384,389,391,396,399,404,409,412,417,422,424,429,432,437,
    439,444,447,455,457,460,465,470,472,477,480,485,487,492,497,500,
    505,508,513,515,520,525,528,533,538,540,545,548,553,558,561,566,
    571,573,578,581,586,588,593,596,601,606,609,614,619,621,626,631,
    634,636,641,644,649,654,657,662,664,669,674,677,682,684,687,692,
    697,699,705,707,712,717,720,725,727,732,737,740,742,747,753,755,
    760,763,768,770,775,778,783,788,790,795,798,803,806,811,813,816,
    821,826,828,833,838,841,846,848,854,856,861,864,869,871,876,879,
    884,886,889,894,896,902,907,909,914,917,919,922,929,932,934,939,
    944,947,952,955,960,962,965,970,972,977,980,985,987,992,995,1000
  };

  typedef logic [15:0] rom_t [256];
  typedef logic [7:0]  start_tbl_t [128];

  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v    = (longint'(FULL_CURRENT) * longint'(CURVE_MILLI[i])) / 1000;
      r[i] = v[15:0];
    end
    return r;
  endfunction

  // Two-segment brightness curve, evaluated for every 7-bit brightness.
  function automatic start_tbl_t build_start_tbl();
    start_tbl_t t;
    int d;
    for (int b = 0; b < 128; b++) begin
      if (b > 50) begin
        d = ((b - 50) * (DUTY_HIGH - DUTY_MID)) / 50 + DUTY_MID;
      end else begin
        d = (b * (DUTY_MID - DUTY_LOW)) / 50 + DUTY_LOW;
      end
      if (d < 0) begin
        d = 0;
      end
      if (d > 255) begin
        d = 255;
      end
      t[b] = 8'(d);
    end
    return t;
  endfunction

  localparam rom_t       CURRENT_ROM = build_rom();
  localparam start_tbl_t START_TBL   = build_start_tbl();

  function automatic logic [7:0] out_duty(logic [7:0] d);
    return INVERT_DUTY ? (DUTY_MAX - d) : d;
  endfunction

endpackage

// ===== rtl/backlight_power_limiter.sv =====
// Init items pass through the scale, init and output states; check items at zero voltage through
// the scale, budget and output states. Other check items run the 30-step divider once, and when
// the limit is lowered the duty search then walks the current ROM
// one entry a cycle.
// One item is in work at a time; the next is accepted once the result is queued.
// Reset (rst, synchronous, active high) clears the limit and loads register defaults.
module backlight_power_limiter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // adc_level[7:0], brightness[14:8], zero[15]
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // duty[7:0], current_limit[23:8]
  output logic        m_tuser   // duty_changed
);

  blp_pkg::blp_cmd_t    cmd;
  blp_pkg::blp_status_t status;
  logic [7:0]           duty;
  logic [15:0]          current_limit;

  blp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  blp_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (s_tuser),
    .in_adc_level      (s_tdata[7:0]),
    .in_brightness     (s_tdata[14:8]),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_duty          (duty),
    .out_duty_changed  (m_tuser),
    .out_current_limit (current_limit)
  );

  assign m_tdata = {current_limit, duty};

endmodule

// ===== rtl/blp_ctrl.sv =====
module blp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  blp_pkg::blp_status_t status,
  output blp_pkg::blp_cmd_t    cmd
);

  blp_pkg::state_t state;
  blp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      blp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = blp_pkg::ST_SCALE;
        end
      end
      blp_pkg::ST_SCALE: begin
        // The item register is loaded by now, so the kind can be seen.
        if (status.kind == blp_pkg::KIND_INIT) begin
          state_next = blp_pkg::ST_INIT;
        end else begin
          state_next = blp_pkg::ST_BUDGET;
        end
      end
      blp_pkg::ST_INIT:     state_next = blp_pkg::ST_OUT;
      blp_pkg::ST_BUDGET: begin
        if (status.volt_zero) begin
          state_next = blp_pkg::ST_OUT;
        end else begin
          state_next = blp_pkg::ST_CAP_LOAD;
        end
      end
      blp_pkg::ST_CAP_LOAD: state_next = blp_pkg::ST_CAP_RUN;
      blp_pkg::ST_CAP_RUN: begin
        if (!status.div_busy) begin
          state_next = blp_pkg::ST_LOWER;
        end
      end
      blp_pkg::ST_LOWER: begin
        if (status.lower) begin
          state_next = blp_pkg::ST_TGT_LOAD;
        end else begin
          state_next = blp_pkg::ST_OUT;
        end
      end
      blp_pkg::ST_TGT_LOAD: state_next = blp_pkg::ST_TGT_RUN;
      blp_pkg::ST_TGT_RUN:  state_next = blp_pkg::ST_SEARCH_INIT;
      blp_pkg::ST_SEARCH_INIT: state_next = blp_pkg::ST_SEARCH;
      blp_pkg::ST_SEARCH: begin
        if (status.found) begin
          state_next = blp_pkg::ST_OUT;
        end
      end
      blp_pkg::ST_OUT: begin
        if (status.out_free) begin
          state_next = blp_pkg::ST_IDLE;
        end
      end
      default: state_next = blp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      blp_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      blp_pkg::ST_SCALE:  cmd.do_scale = 1'b1;
      blp_pkg::ST_INIT:   cmd.do_init = 1'b1;
      blp_pkg::ST_BUDGET: cmd.do_budget = 1'b1;
      blp_pkg::ST_CAP_LOAD: cmd.div_load = 1'b1;
      blp_pkg::ST_LOWER: cmd.do_lower = 1'b1;
      blp_pkg::ST_TGT_LOAD: cmd.tgt_mul = 1'b1;
      blp_pkg::ST_TGT_RUN:  cmd.tgt_scale = 1'b1;
      blp_pkg::ST_SEARCH_INIT: cmd.search_init = 1'b1;
      blp_pkg::ST_SEARCH:      cmd.search_step = 1'b1;
      blp_pkg::ST_OUT:         cmd.out_load = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/blp_dp.sv =====
module blp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_kind,
  input  logic [7:0]           in_adc_level,
  input  logic [6:0]           in_brightness,
  input  blp_pkg::blp_cmd_t    cmd,
  output blp_pkg::blp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_duty,
  output logic                 out_duty_changed,
  output logic [15:0]          out_current_limit
);

  logic [10:0] volt_threshold [4];
  logic [15:0] watt_budget [4];

  logic        kind;
  logic [7:0]  adc_level;
  logic [6:0]  brightness;
  logic [10:0] voltage;
  logic [15:0] budget;
  logic [15:0] limit;
  logic [15:0] target;
  logic [7:0]  idx;
  logic [7:0]  res_duty;
  logic        res_changed;

  logic [blp_pkg::DIV_W-1:0] quo;
  logic [10:0]               rem;
  logic [10:0]               dvs;
  logic [4:0]                cnt;

  logic [22:0]               pct_prod;
  logic [16:0]               pct_quo;
  logic [46:0]               pct_full;

  logic [18:0]               volt_prod;
  logic [15:0]               budget_sel;
  logic [blp_pkg::DIV_W-1:0] div_dividend;
  logic [12:0]               trial;
  logic [7:0]                start_d;
  logic                      found;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_threshold[0] <= 11'd0;
      volt_threshold[1] <= 11'd1100;
      volt_threshold[2] <= 11'd1100;
      volt_threshold[3] <= 11'd1100;
      for (int i = 0; i < 4; i++) begin
        watt_budget[i] <= 16'd0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        blp_pkg::REG_VTH0: volt_threshold[0] <= cfg_data[10:0];
        blp_pkg::REG_VTH1: volt_threshold[1] <= cfg_data[10:0];
        blp_pkg::REG_VTH2: volt_threshold[2] <= cfg_data[10:0];
        blp_pkg::REG_VTH3: volt_threshold[3] <= cfg_data[10:0];
        blp_pkg::REG_WB0:  watt_budget[0] <= cfg_data;
        blp_pkg::REG_WB1:  watt_budget[1] <= cfg_data;
        blp_pkg::REG_WB2:  watt_budget[2] <= cfg_data;
        blp_pkg::REG_WB3:  watt_budget[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign volt_prod = 19'(blp_pkg::VOLT_SCALE) * 19'(adc_level);
  assign start_d   = blp_pkg::START_TBL[brightness];

  // The highest tier whose threshold is strictly exceeded wins.
  always_comb begin
    if (voltage > volt_threshold[3]) begin
      budget_sel = watt_budget[3];
    end else if (voltage > volt_threshold[2]) begin
      budget_sel = watt_budget[2];
    end else if (voltage > volt_threshold[1]) begin
      budget_sel = watt_budget[1];
    end else if (voltage > volt_threshold[0]) begin
      budget_sel = watt_budget[0];
    end else begin
      budget_sel = 16'd0;
    end
  end

  assign div_dividend = blp_pkg::DIV_W'(budget) * blp_pkg::DIV_W'(blp_pkg::WATT_SCALE);
  assign pct_full     = 47'(pct_prod) * 47'(blp_pkg::PCT_RECIP);

  assign trial = {1'b0, rem, quo[blp_pkg::DIV_W-1]} - {2'b00, dvs};
  assign found = (target < blp_pkg::CURRENT_ROM[idx]) || (idx == blp_pkg::DUTY_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind       <= in_kind;
      adc_level  <= in_adc_level;
      brightness <= in_brightness;
    end
    if (cmd.do_scale) begin
      voltage <= volt_prod[18:8];
    end
    if (cmd.do_budget) begin
      budget      <= budget_sel;
      res_duty    <= 8'd0;
      res_changed <= 1'b0;
    end
    if (cmd.do_init) begin
      res_duty    <= blp_pkg::out_duty(start_d);
      res_changed <= 1'b0;
    end
    if (cmd.do_lower && status.lower) begin
      res_changed <= 1'b1;
    end
    // The target current is limit * brightness / 100: a registered multiply, then a registered scale.
    if (cmd.tgt_mul) begin
      pct_prod <= 23'(limit) * 23'(brightness);
    end
    if (cmd.tgt_scale) begin
      pct_quo <= pct_full[blp_pkg::PCT_SHIFT +: 17];
    end
    if (cmd.search_init) begin
      idx <= 8'd0;
      if (pct_quo > 17'(blp_pkg::FULL_CURRENT)) begin
        target <= 16'(blp_pkg::FULL_CURRENT);
      end else begin
        target <= pct_quo[15:0];
      end
    end
    if (cmd.search_step) begin
      if (found) begin
        res_duty <= blp_pkg::out_duty(idx);
      end else begin
        idx <= idx + 8'd1;
      end
    end
    // Restoring divider, one quotient bit a cycle.
    if (cmd.div_load) begin
      quo <= div_dividend;
      dvs <= voltage;
      rem <= 11'd0;
    end else if (cnt != 5'd0) begin
      if (!trial[12]) begin
        rem <= trial[10:0];
        quo <= {quo[blp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[9:0], quo[blp_pkg::DIV_W-1]};
        quo <= {quo[blp_pkg::DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_duty          <= res_duty;
      out_duty_changed  <= res_changed;
      out_current_limit <= limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.div_load) begin
        cnt <= blp_pkg::DIV_STEPS;
      end else if (cnt != 5'd0) begin
        cnt <= cnt - 5'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The current limit is cleared by reset since it is architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 16'd0;
    end else if (cmd.do_init) begin
      limit <= blp_pkg::CURRENT_ROM[start_d];
    end else if (cmd.do_lower && status.lower) begin
      limit <= quo[15:0];
    end
  end

  always_comb begin
    status.kind      = kind;
    status.volt_zero = (voltage == 11'd0);
    status.div_busy  = (cnt != 5'd0);
    status.lower     = (blp_pkg::DIV_W'(limit) > quo);
    status.found     = found;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int DIRECTED_SPLIT = 9;
  localparam int DRAIN_CYCLES   = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int MAX_REPORTS    = 150;

  // Brightness-to-current curve in thousandths of full current.
  localparam int unsigned CURVE_PERMILLE [256] = '{
    0,5,8,13,15,20,25,28,30,35,38,43,45,51,56,58,
    63,66,71,73,76,81,83,88,91,96,98,104,106,111,116,119,
    124,126,131,134,139,141,146,149,154,159,162,167,169,174,177,182,
    184,189,194,197,202,205,210,212,217,222,225,230,232,237,240,245,
    250,253,258,260,265,268,273,275,280,283,288,290,295,301,303,308,
    311,316,321,323,328,333,336,341,343,348,351,356,361,364,369,374,
    376,381,384,389,391,396,399,404,409,412,417,422,424,429,432,437,
    439,444,447,455,457,460,465,470,472,477,480,485,487,492,497,500,
    505,508,513,515,520,525,528,533,538,540,545,548,553,558,561,566,
    571,573,578,581,586,588,593,596,601,606,609,614,619,621,626,631,
    634,636,641,644,649,654,657,662,664,669,674,677,682,684,687,692,
    697,699,705,707,712,717,720,725,727,732,737,740,742,747,753,755,
    760,763,768,770,775,778,783,788,790,795,798,803,806,811,813,816,
    821,826,828,833,838,841,846,848,854,856,861,864,869,871,876,879,
    884,886,889,894,896,902,907,909,914,917,919,922,929,932,934,939,
    944,947,952,955,960,962,965,970,972,977,980,985,987,992,995,1000
  };

  typedef struct packed {
    logic [7:0]  duty;
    logic        changed;
    logic [15:0] limit;
  } limit_update_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  adc;
    logic [6:0]  bright;
    logic        typed;
    logic [7:0]  duty;
    logic        changed;
    logic [15:0] limit;
  } stim_row_t;

  // Rows before DIRECTED_SPLIT run with the reset settings; the rest with the
  // directed tier settings, whose two middle thresholds sit on reachable voltages.
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    '{blp_pkg::KIND_CHECK, 8'd255, 7'd100, 1'b1, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd0,   1'b1, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd100, 1'b1, 8'd255, 1'b0, 16'd1000},
    '{blp_pkg::KIND_CHECK, 8'd0,   7'd100, 1'b1, 8'd0,   1'b0, 16'd1000},
    '{blp_pkg::KIND_CHECK, 8'd255, 7'd100, 1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd17,  7'd127, 1'b1, 8'd255, 1'b0, 16'd1000},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd50,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd51,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd1,   7'd51,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd100, 1'b1, 8'd255, 1'b0, 16'd1000},
    '{blp_pkg::KIND_CHECK, 8'd237, 7'd100, 1'b1, 8'd0,   1'b0, 16'd1000},
    '{blp_pkg::KIND_CHECK, 8'd236, 7'd100, 1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd142, 7'd100, 1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd141, 7'd80,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd71,  7'd60,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd72,  7'd60,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd25,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd1,   7'd25,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd100, 1'b1, 8'd255, 1'b0, 16'd1000},
    '{blp_pkg::KIND_CHECK, 8'd13,  7'd127, 1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd0,   7'd127, 1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_INIT,  8'd0,   7'd75,  1'b0, 8'd0,   1'b0, 16'd0},
    '{blp_pkg::KIND_CHECK, 8'd128, 7'd0,   1'b0, 8'd0,   1'b0, 16'd0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  // Predictor state: settings, limit and current table.
  logic [10:0] vth [4];
  logic [15:0] wbud [4];
  logic [15:0] lim_now;
  logic [15:0] cur_rom [256];

  limit_update_t limit_updates_q [$];
  limit_update_t want;

  int errors       = 0;
  int burst_left   = 0;
  int init_count   = 0;
  int check_count  = 0;
  int results_seen = 0;
  int lowered_seen = 0;
  int settings_cnt = 0;
  int stall_hold   = 0;
  int quiet_cycles = 0;
  longint cycle_no = 0;

  backlight_power_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic limit_update_t predict_limit_update(logic kind, logic [7:0] adc,
                                                         logic [6:0] bright);
    limit_update_t r;
    int d;
    int b;
    int i;
    int unsigned volts;
    longint unsigned budget;
    longint unsigned cap;
    longint unsigned target;
    r = '0;
    if (kind == blp_pkg::KIND_INIT) begin
      b = int'(bright);
      if (b > 50) begin
        d = ((b - 50) * (blp_pkg::DUTY_HIGH - blp_pkg::DUTY_MID)) / 50 + blp_pkg::DUTY_MID;
      end else begin
        d = (b * (blp_pkg::DUTY_MID - blp_pkg::DUTY_LOW)) / 50 + blp_pkg::DUTY_LOW;
      end
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      lim_now = cur_rom[d];
      r.duty = blp_pkg::INVERT_DUTY ? 8'(255 - d) : 8'(d);
    end else begin
      volts = (32'd1086 * 32'(adc)) >> 8;
      if (volts > vth[3]) budget = wbud[3];
      else if (volts > vth[2]) budget = wbud[2];
      else if (volts > vth[1]) budget = wbud[1];
      else if (volts > vth[0]) budget = wbud[0];
      else budget = 0;
      // A zero voltage leaves everything as it was.
      if (volts != 0) begin
        cap = (budget * 64'd10000) / 64'(volts);
        if (64'(lim_now) > cap) begin
          lim_now = cap[15:0];
          r.changed = 1'b1;
          target = (64'(lim_now) * 64'(bright)) / 64'd100;
          if (target > 64'(blp_pkg::FULL_CURRENT)) target = 64'(blp_pkg::FULL_CURRENT);
          i = 0;
          while (i < 255 && target >= 64'(cur_rom[i])) i++;
          r.duty = blp_pkg::INVERT_DUTY ? 8'(255 - i) : 8'(i);
        end
      end
    end
    r.limit = lim_now;
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] adc, input logic [6:0] bright,
                           input bit typed, input limit_update_t typed_res);
    limit_update_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, bright, adc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_limit_update(kind, adc, bright);
    limit_updates_q.push_back(typed ? typed_res : r);
    if (kind == blp_pkg::KIND_INIT) init_count++;
    else check_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (limit_updates_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < blp_pkg::REG_WB0) vth[2'(idx - blp_pkg::REG_VTH0)] = val[10:0];
    else wbud[2'(idx - blp_pkg::REG_WB0)] = val;
  endtask

  task automatic load_settings(input int ph);
    int t [4];
    int w [4];
    case (ph)
      0: begin
        t = '{0, 301, 598, 1001};
        w = '{5, 20, 40, 65535};
      end
      1: begin
        t = '{0, 1100, 1100, 1100};
        w = '{0, 0, 0, 0};
      end
      2: begin
        t = '{0, 0, 0, 0};
        w = '{0, 0, 0, 0};
      end
      3: begin
        // No voltage reaches a tier, so every budget is zero.
        t = '{1100, 1100, 1100, 1100};
        w = '{65535, 65535, 65535, 65535};
      end
      4: begin
        t = '{0, 0, 0, 0};
        w = '{65535, 65535, 65535, 65535};
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          if (ph % 2 == 0) begin
            // Ordered tiers with budgets small enough to bite on a 1000 mA limit.
            if (i == 0) t[i] = $urandom_range(0, 300);
            else t[i] = t[i - 1] + $urandom_range(0, 350);
            if (t[i] > 1100) t[i] = 1100;
            w[i] = $urandom_range(0, 80);
          end else begin
            t[i] = $urandom_range(0, 1100);
            case ($urandom_range(0, 3))
              0: w[i] = 0;
              1: w[i] = 65535;
              default: w[i] = $urandom_range(0, 150);
            endcase
          end
        end
      end
    endcase
    wait_idle();
    for (int i = 0; i < 4; i++) write_reg(blp_pkg::REG_VTH0 + 3'(i), 16'(t[i]));
    for (int i = 0; i < 4; i++) write_reg(blp_pkg::REG_WB0 + 3'(i), 16'(w[i]));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  task automatic compare_field(input string what, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endtask

  // Receiver: calm stretches, short random stalls, and long stalls in turn.
  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      m_tready   <= 1'b0;
    end else if ((cycle_no / 900) % 3 != 0 && $urandom_range(0, 3) == 0) begin
      stall_hold <= ((cycle_no / 900) % 3 == 2) ? $urandom_range(0, 24) : $urandom_range(0, 3);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) lowered_seen++;
      if (limit_updates_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: duty %0d, changed %0d, limit %0d",
                 $time, m_tdata[7:0], m_tuser, m_tdata[23:8]);
      end else begin
        want = limit_updates_q.pop_front();
        compare_field("duty", 16'(want.duty), 16'(m_tdata[7:0]));
        compare_field("duty_changed", 16'(want.changed), 16'(m_tuser));
        compare_field("current_limit", want.limit, m_tdata[23:8]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int n;
    int b;
    int a;
    limit_update_t tr;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = blp_pkg::KIND_INIT;
    vth       = '{11'd0, 11'd1100, 11'd1100, 11'd1100};
    wbud      = '{16'd0, 16'd0, 16'd0, 16'd0};
    lim_now   = '0;
    for (int i = 0; i < 256; i++) begin
      cur_rom[i] = 16'((blp_pkg::FULL_CURRENT * CURVE_PERMILLE[i]) / 1000);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (r == DIRECTED_SPLIT) load_settings(0);
      tr.duty    = DIRECTED_ROWS[r].duty;
      tr.changed = DIRECTED_ROWS[r].changed;
      tr.limit   = DIRECTED_ROWS[r].limit;
      send_item(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].adc, DIRECTED_ROWS[r].bright,
                DIRECTED_ROWS[r].typed, tr);
    end

    // Mostly an init followed by a few checks, with stray items mixed in.
    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      load_settings(ph);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 1'b0, '0);
          sent++;
        end else begin
          b = ($urandom_range(0, 5) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
          send_item(blp_pkg::KIND_INIT, 8'($urandom_range(0, 255)), 7'(b), 1'b0, '0);
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0: a = 0;
              1: a = $urandom_range(1, 15);
              2: a = 255;
              default: a = $urandom_range(0, 255);
            endcase
            send_item(blp_pkg::KIND_CHECK, 8'(a),
                      7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : b),
                      1'b0, '0);
          end
          sent += n + 1;
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d init and %0d check items under %0d register settings.",
             init_count, check_count, settings_cnt);
    $display("Compared %0d results, %0d of which lowered the current limit.",
             results_seen, lowered_seen);
    if (errors == 0 && limit_updates_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/blp_pkg.sv
rtl/blp_ctrl.sv
rtl/blp_dp.sv
rtl/backlight_power_limiter.sv
dv/testbench.sv
